// ===== sv/sha1sh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1sh_pkg
// Shared constants, types and command bundle for the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
package sha1sh_pkg;

  // Input operation codes
  localparam logic [1:0] OP_ABSORB = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_PEEK   = 2'd2;

  localparam logic [5:0]  LAST_BYTE     = 6'd63;
  localparam logic [5:0]  LEN_POS       = 6'd56;
  localparam logic [6:0]  LAST_ROUND    = 7'd79;
  localparam logic [6:0]  ROUND_PARITY1 = 7'd20;
  localparam logic [6:0]  ROUND_MAJ     = 7'd40;
  localparam logic [6:0]  ROUND_PARITY2 = 7'd60;
  localparam logic [2:0]  LAST_WORD     = 3'd4;
  localparam logic [7:0]  PAD_MARK_BYTE = 8'h80;
  localparam logic [63:0] BLOCK_BITS    = 64'd512;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_CONST [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  // Sixteen big-endian words, word 0 in the most significant position
  typedef logic [0:15][31:0] block_t;

  typedef enum logic [1:0] {
    PAD_ZERO,
    PAD_MARK,
    PAD_LEN
  } pad_sel_t;

  typedef struct packed {
    logic       buf_shift;
    logic       blk_load;
    logic       pad_start;
    logic       pad_shift;
    pad_sel_t   pad_sel;
    logic       hash_init;
    logic       use_copy;
    logic       round;
    logic [6:0] round_t;
    logic       hash_add;
    logic       emit;
    logic [2:0] emit_idx;
    logic       chain_reset;
    logic [5:0] fill;
  } cmd_t;

endpackage

// ===== sv/sha1sh_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1sh_if
// Valid/ready channels: message items in, digest words out.
// ----------------------------------------------------------------------------
interface sha1sh_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface sha1sh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;

  modport source (output valid, output digest_word, output word_index, output last,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last,
                output ready);
endinterface

// ===== sv/sha1sh_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1sh_ctrl
// Sequencer: byte count, padding position, round count and digest emission.
// ----------------------------------------------------------------------------
module sha1sh_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               msg_valid,
  output logic               msg_ready,
  input  logic [1:0]         msg_op,
  output logic               dig_valid,
  input  logic               dig_ready,
  output sha1sh_pkg::cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_ADD,
    S_EMIT
  } state_t;

  state_t     state;
  logic [5:0] fill;
  logic [5:0] pad_pos;
  logic [6:0] rnd;
  logic [2:0] idx;
  logic       first_blk;
  logic       use_copy;
  logic       finish;

  logic msg_xfer;
  logic slot_free;
  logic len_blk;

  assign msg_ready = (state == S_IDLE);
  assign msg_xfer  = msg_valid && msg_ready;
  assign slot_free = !dig_valid || dig_ready;
  // length goes in the first pad block only when it still has room
  assign len_blk   = !first_blk || (fill < sha1sh_pkg::LEN_POS);

  always_comb begin
    cmd          = '0;
    cmd.pad_sel  = sha1sh_pkg::PAD_ZERO;
    cmd.use_copy = use_copy;
    cmd.round_t  = rnd;
    cmd.emit_idx = idx;
    cmd.fill     = fill;
    unique case (state)
      S_IDLE: begin
        if (msg_xfer) begin
          if (msg_op == sha1sh_pkg::OP_ABSORB) begin
            cmd.buf_shift = 1'b1;
            if (fill == sha1sh_pkg::LAST_BYTE) begin
              cmd.blk_load  = 1'b1;
              cmd.hash_init = 1'b1;
              cmd.use_copy  = 1'b0;
            end
          end else if (msg_op == sha1sh_pkg::OP_FINISH || msg_op == sha1sh_pkg::OP_PEEK) begin
            cmd.pad_start = 1'b1;
          end
        end
      end
      S_PAD: begin
        cmd.pad_shift = 1'b1;
        if (first_blk && pad_pos == fill) begin
          cmd.pad_sel = sha1sh_pkg::PAD_MARK;
        end else if (len_blk && pad_pos >= sha1sh_pkg::LEN_POS) begin
          cmd.pad_sel = sha1sh_pkg::PAD_LEN;
        end
        if (pad_pos == sha1sh_pkg::LAST_BYTE) begin
          cmd.hash_init = 1'b1;
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
      end
      S_ADD: begin
        cmd.hash_add = 1'b1;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit = 1'b1;
          if (idx == sha1sh_pkg::LAST_WORD && finish) begin
            cmd.chain_reset = 1'b1;
          end
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      pad_pos   <= '0;
      rnd       <= '0;
      idx       <= '0;
      first_blk <= 1'b0;
      use_copy  <= 1'b0;
      finish    <= 1'b0;
      dig_valid <= 1'b0;
    end else begin
      // raise on a new word, drop once the waiting word is taken
      if (state == S_EMIT && slot_free) begin
        dig_valid <= 1'b1;
      end else if (dig_ready) begin
        dig_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (msg_xfer) begin
            if (msg_op == sha1sh_pkg::OP_ABSORB) begin
              if (fill == sha1sh_pkg::LAST_BYTE) begin
                fill     <= '0;
                use_copy <= 1'b0;
                rnd      <= '0;
                state    <= S_ROUND;
              end else begin
                fill <= fill + 6'd1;
              end
            end else if (msg_op == sha1sh_pkg::OP_FINISH || msg_op == sha1sh_pkg::OP_PEEK) begin
              finish    <= (msg_op == sha1sh_pkg::OP_FINISH);
              use_copy  <= 1'b1;
              first_blk <= 1'b1;
              pad_pos   <= fill;
              state     <= S_PAD;
            end
          end
        end
        S_PAD: begin
          if (pad_pos == sha1sh_pkg::LAST_BYTE) begin
            rnd   <= '0;
            state <= S_ROUND;
          end else begin
            pad_pos <= pad_pos + 6'd1;
          end
        end
        S_ROUND: begin
          if (rnd == sha1sh_pkg::LAST_ROUND) begin
            state <= S_ADD;
          end else begin
            rnd <= rnd + 7'd1;
          end
        end
        S_ADD: begin
          if (!use_copy) begin
            state <= S_IDLE;
          end else if (first_blk && fill >= sha1sh_pkg::LEN_POS) begin
            // no room for the length: run one more all-pad block
            first_blk <= 1'b0;
            pad_pos   <= '0;
            state     <= S_PAD;
          end else begin
            idx   <= '0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            if (idx == sha1sh_pkg::LAST_WORD) begin
              if (finish) begin
                fill <= '0;
              end
              state <= S_IDLE;
            end else begin
              idx <= idx + 3'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(dig_valid) |-> $past(state == S_EMIT))
    else $error("digest word raised outside emission");

  a_mark_pos: assert property (@(posedge clk) disable iff (rst)
    (cmd.pad_sel == sha1sh_pkg::PAD_MARK) |-> (state == S_PAD && first_blk && pad_pos == fill))
    else $error("end-of-message mark at wrong position");

  a_len_pos: assert property (@(posedge clk) disable iff (rst)
    (cmd.pad_sel == sha1sh_pkg::PAD_LEN) |-> (pad_pos >= sha1sh_pkg::LEN_POS && len_blk))
    else $error("length byte outside the length field");

  a_fill_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && $past(state != S_IDLE)) |-> $stable(fill))
    else $error("byte count changed during compression or digest");

endmodule

// ===== sv/sha1sh_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1sh_datapath
// Block buffer, schedule window, round logic, chaining words and digest output.
// ----------------------------------------------------------------------------
module sha1sh_datapath (
  input  logic               clk,
  input  logic               rst,
  input  sha1sh_pkg::cmd_t   cmd,
  input  logic [7:0]         data_byte,
  output logic [31:0]        digest_word,
  output logic [2:0]         word_index,
  output logic               last
);

  logic [511:0]          blk_buf;
  logic [511:0]          blk_buf_next;
  sha1sh_pkg::block_t    sched;
  logic [519:0]          sched_byte_shift;
  logic [31:0]           chain [5];
  logic [31:0]           hw [5];
  logic [31:0]           wk [5];
  logic [31:0]           hsel [5];
  logic [31:0]           hsum [5];
  logic [63:0]           total;
  logic [63:0]           len_sh;
  logic [7:0]            pad_byte;
  logic [31:0]           w;
  logic [31:0]           w_mix;
  logic [31:0]           w_new;
  logic [31:0]           f;
  logic [31:0]           k;
  logic [31:0]           t_sum;

  assign blk_buf_next = {blk_buf[503:0], data_byte};

  always_comb begin
    case (cmd.pad_sel)
      sha1sh_pkg::PAD_MARK: pad_byte = sha1sh_pkg::PAD_MARK_BYTE;
      sha1sh_pkg::PAD_LEN:  pad_byte = len_sh[63:56];
      default:              pad_byte = 8'h00;
    endcase
  end

  assign sched_byte_shift = {sched, pad_byte};

  assign w     = sched[0];
  assign w_mix = sched[13] ^ sched[8] ^ sched[2] ^ sched[0];
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    if (cmd.round_t < sha1sh_pkg::ROUND_PARITY1) begin
      f = (wk[1] & wk[2]) | (~wk[1] & wk[3]);
      k = sha1sh_pkg::K_CONST[0];
    end else if (cmd.round_t < sha1sh_pkg::ROUND_MAJ) begin
      f = wk[1] ^ wk[2] ^ wk[3];
      k = sha1sh_pkg::K_CONST[1];
    end else if (cmd.round_t < sha1sh_pkg::ROUND_PARITY2) begin
      f = (wk[1] & wk[2]) | (wk[1] & wk[3]) | (wk[2] & wk[3]);
      k = sha1sh_pkg::K_CONST[2];
    end else begin
      f = wk[1] ^ wk[2] ^ wk[3];
      k = sha1sh_pkg::K_CONST[3];
    end
  end

  assign t_sum = {wk[0][26:0], wk[0][31:27]} + f + wk[4] + k + w;

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      hsel[i] = cmd.use_copy ? hw[i] : chain[i];
      hsum[i] = hsel[i] + wk[i];
    end
  end

  // Running hash state
  always_ff @(posedge clk) begin
    if (rst || cmd.chain_reset) begin
      chain <= sha1sh_pkg::H_INIT;
      total <= '0;
    end else if (cmd.hash_add && !cmd.use_copy) begin
      chain <= hsum;
      total <= total + sha1sh_pkg::BLOCK_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.buf_shift) begin
      blk_buf <= blk_buf_next;
    end

    if (cmd.blk_load) begin
      sched <= sha1sh_pkg::block_t'(blk_buf_next);
    end else if (cmd.pad_start) begin
      sched <= sha1sh_pkg::block_t'(blk_buf);
    end else if (cmd.pad_shift) begin
      sched <= sha1sh_pkg::block_t'(sched_byte_shift[511:0]);
    end else if (cmd.round) begin
      sched <= sha1sh_pkg::block_t'({sched[1:15], w_new});
    end

    if (cmd.pad_start) begin
      len_sh <= total + {55'd0, cmd.fill, 3'd0};
    end else if (cmd.pad_shift && cmd.pad_sel == sha1sh_pkg::PAD_LEN) begin
      len_sh <= {len_sh[55:0], 8'h00};
    end

    if (cmd.hash_init) begin
      wk <= hsel;
    end else if (cmd.round) begin
      wk[0] <= t_sum;
      wk[1] <= wk[0];
      wk[2] <= {wk[1][1:0], wk[1][31:2]};
      wk[3] <= wk[2];
      wk[4] <= wk[3];
    end

    // Digest copy: rotate one word out per emitted result
    if (cmd.pad_start) begin
      hw <= chain;
    end else if (cmd.hash_add && cmd.use_copy) begin
      hw <= hsum;
    end else if (cmd.emit) begin
      hw[0] <= hw[1];
      hw[1] <= hw[2];
      hw[2] <= hw[3];
      hw[3] <= hw[4];
      hw[4] <= hw[0];
    end

    if (cmd.emit) begin
      digest_word <= hw[0];
      word_index  <= cmd.emit_idx;
      last        <= (cmd.emit_idx == sha1sh_pkg::LAST_WORD);
    end
  end

endmodule

// ===== sv/sha1_stream_hasher_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_stream_hasher_unit
// SHA-1 over a byte stream with finish and non-destructive peek of the digest.
// ----------------------------------------------------------------------------
// A data byte is taken while msg.ready is high. The 64th byte of a block
// starts a compression on the single round unit: 80 rounds at one per cycle,
// then the chaining add; msg.ready stays low through the rounds and the add.
// Finish and peek shift the padding into the schedule one byte per cycle,
// compress, repeat with a full 64-byte pad block when fewer than 8 bytes
// remain for the length, then transfer the five digest words at one per cycle
// as the sink accepts them. After the fifth word is loaded the block takes
// new items while that word still waits.
module sha1_stream_hasher_unit (
  input logic          clk,
  input logic          rst,
  sha1sh_in_if.sink    msg,
  sha1sh_out_if.source dig
);

  sha1sh_pkg::cmd_t cmd;

  sha1sh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg.valid),
    .msg_ready (msg.ready),
    .msg_op    (msg.op),
    .dig_valid (dig.valid),
    .dig_ready (dig.ready),
    .cmd       (cmd)
  );

  sha1sh_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (msg.data_byte),
    .digest_word (dig.digest_word),
    .word_index  (dig.word_index),
    .last        (dig.last)
  );

endmodule
